// ===== hw/rtl/aabb_collide_and_resolve_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box collision pipeline
// Concurrent checks clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLIDE_AND_RESOLVE_MACROS_SVH
`define AABB_COLLIDE_AND_RESOLVE_MACROS_SVH

// same-cycle implication
`define ACR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Shared constants of the box collision pipeline.
// ----------------------------------------------------------------------------
package acr_pkg;

  // box sizes are this many bits narrower than coordinates
  localparam int SIZE_GAP = 2;

  // push axis codes
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

endpackage

// ===== hw/rtl/acr_ifs.sv =====
// ----------------------------------------------------------------------------
// acr stream interfaces
// Valid/ready channels for box pairs in and resolved movers out.
// ----------------------------------------------------------------------------
interface acr_in_if
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        mover_x;
  logic signed [COORD_BITS-1:0]        mover_y;
  logic signed [COORD_BITS-1:0]        mover_vx;
  logic signed [COORD_BITS-1:0]        mover_vy;
  logic        [COORD_BITS-SIZE_GAP-1:0] mover_width;
  logic        [COORD_BITS-SIZE_GAP-1:0] mover_height;
  logic signed [COORD_BITS-1:0]        tile_x;
  logic signed [COORD_BITS-1:0]        tile_y;
  logic signed [COORD_BITS-1:0]        tile_vx;
  logic signed [COORD_BITS-1:0]        tile_vy;
  logic        [COORD_BITS-SIZE_GAP-1:0] tile_width;
  logic        [COORD_BITS-SIZE_GAP-1:0] tile_height;

  modport source (
    output valid, mover_x, mover_y, mover_vx, mover_vy, mover_width, mover_height,
    output tile_x, tile_y, tile_vx, tile_vy, tile_width, tile_height,
    input  ready
  );
  modport sink (
    input  valid, mover_x, mover_y, mover_vx, mover_vy, mover_width, mover_height,
    input  tile_x, tile_y, tile_vx, tile_vy, tile_width, tile_height,
    output ready
  );
endinterface

interface acr_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         push_axis;
  logic signed [COORD_BITS-1:0] new_x;
  logic signed [COORD_BITS-1:0] new_y;
  logic signed [COORD_BITS-1:0] new_vx;
  logic signed [COORD_BITS-1:0] new_vy;

  modport source (
    output valid, hit, push_axis, new_x, new_y, new_vx, new_vy,
    input  ready
  );
  modport sink (
    input  valid, hit, push_axis, new_x, new_y, new_vx, new_vy,
    output ready
  );
endinterface

// ===== hw/rtl/acr_diff.sv =====
// ----------------------------------------------------------------------------
// acr_diff
// First stage: relative position, relative velocity and size sums.
// ----------------------------------------------------------------------------
module acr_diff
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  acr_in_if.sink                            pair,
  output logic                              valid,
  input  logic                              dn_ready,
  output logic signed [COORD_BITS:0]        dx,
  output logic signed [COORD_BITS:0]        dy,
  output logic signed [COORD_BITS:0]        rvx,
  output logic signed [COORD_BITS:0]        rvy,
  output logic        [COORD_BITS-SIZE_GAP:0] sumw,
  output logic        [COORD_BITS-SIZE_GAP:0] sumh,
  output logic signed [COORD_BITS-1:0]      mx,
  output logic signed [COORD_BITS-1:0]      my,
  output logic signed [COORD_BITS-1:0]      mvx,
  output logic signed [COORD_BITS-1:0]      mvy,
  output logic signed [COORD_BITS-1:0]      tx,
  output logic signed [COORD_BITS-1:0]      ty
);
  localparam int CB = COORD_BITS;

  assign pair.ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pair.ready) begin
      valid <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair.ready && pair.valid) begin
      dx   <= $signed({pair.mover_x[CB-1], pair.mover_x}) -
              $signed({pair.tile_x[CB-1], pair.tile_x});
      dy   <= $signed({pair.mover_y[CB-1], pair.mover_y}) -
              $signed({pair.tile_y[CB-1], pair.tile_y});
      rvx  <= $signed({pair.mover_vx[CB-1], pair.mover_vx}) -
              $signed({pair.tile_vx[CB-1], pair.tile_vx});
      rvy  <= $signed({pair.mover_vy[CB-1], pair.mover_vy}) -
              $signed({pair.tile_vy[CB-1], pair.tile_vy});
      sumw <= {1'b0, pair.mover_width} + {1'b0, pair.tile_width};
      sumh <= {1'b0, pair.mover_height} + {1'b0, pair.tile_height};
      mx   <= pair.mover_x;
      my   <= pair.mover_y;
      mvx  <= pair.mover_vx;
      mvy  <= pair.mover_vy;
      tx   <= pair.tile_x;
      ty   <= pair.tile_y;
    end
  end
endmodule

// ===== hw/rtl/acr_mul.sv =====
// ----------------------------------------------------------------------------
// acr_mul
// Second stage: dot product terms, doubled overlaps and saturated push-out
// positions on both axes.
// ----------------------------------------------------------------------------
module acr_mul
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_BITS:0]        dx,
  input  logic signed [COORD_BITS:0]        dy,
  input  logic signed [COORD_BITS:0]        rvx,
  input  logic signed [COORD_BITS:0]        rvy,
  input  logic        [COORD_BITS-SIZE_GAP:0] sumw,
  input  logic        [COORD_BITS-SIZE_GAP:0] sumh,
  input  logic signed [COORD_BITS-1:0]      mx_in,
  input  logic signed [COORD_BITS-1:0]      my_in,
  input  logic signed [COORD_BITS-1:0]      mvx_in,
  input  logic signed [COORD_BITS-1:0]      mvy_in,
  input  logic signed [COORD_BITS-1:0]      tx,
  input  logic signed [COORD_BITS-1:0]      ty,
  output logic                              valid,
  input  logic                              dn_ready,
  output logic signed [2*COORD_BITS+1:0]    px,
  output logic signed [2*COORD_BITS+1:0]    py,
  output logic signed [COORD_BITS+2:0]      ox2,
  output logic signed [COORD_BITS+2:0]      oy2,
  output logic signed [COORD_BITS-1:0]      cx,
  output logic signed [COORD_BITS-1:0]      cy,
  output logic signed [COORD_BITS-1:0]      mx,
  output logic signed [COORD_BITS-1:0]      my,
  output logic signed [COORD_BITS-1:0]      mvx,
  output logic signed [COORD_BITS-1:0]      mvy
);
  localparam int CB = COORD_BITS;
  localparam int DB = CB + 1;
  localparam int OB = CB + 3;
  localparam int SB = CB - SIZE_GAP;
  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

  logic        [DB-1:0]   adx, ady;
  logic        [SB-1:0]   halfw, halfh;
  logic signed [CB:0]     wide_x, wide_y;
  logic signed [CB-1:0]   cx_next, cy_next;
  logic signed [OB-1:0]   ox2_next, oy2_next;
  logic                   dx_pos, dy_pos;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    adx = dx[DB-1] ? (~dx + 1'b1) : dx;
    ady = dy[DB-1] ? (~dy + 1'b1) : dy;
    ox2_next = $signed({{(OB-SB-1){1'b0}}, sumw}) - $signed({1'b0, adx, 1'b0});
    oy2_next = $signed({{(OB-SB-1){1'b0}}, sumh}) - $signed({1'b0, ady, 1'b0});

    // zero offset goes to the negative side
    dx_pos = !dx[DB-1] && (dx != '0);
    dy_pos = !dy[DB-1] && (dy != '0);
    halfw  = sumw[SB:1];
    halfh  = sumh[SB:1];
    wide_x = dx_pos ? $signed({tx[CB-1], tx}) + $signed({3'b000, halfw})
                    : $signed({tx[CB-1], tx}) - $signed({3'b000, halfw});
    wide_y = dy_pos ? $signed({ty[CB-1], ty}) + $signed({3'b000, halfh})
                    : $signed({ty[CB-1], ty}) - $signed({3'b000, halfh});

    if (wide_x[CB] != wide_x[CB-1]) begin
      cx_next = wide_x[CB] ? COORD_MIN : COORD_MAX;
    end else begin
      cx_next = wide_x[CB-1:0];
    end
    if (wide_y[CB] != wide_y[CB-1]) begin
      cy_next = wide_y[CB] ? COORD_MIN : COORD_MAX;
    end else begin
      cy_next = wide_y[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      px  <= dx * rvx;
      py  <= dy * rvy;
      ox2 <= ox2_next;
      oy2 <= oy2_next;
      cx  <= cx_next;
      cy  <= cy_next;
      mx  <= mx_in;
      my  <= my_in;
      mvx <= mvx_in;
      mvy <= mvy_in;
    end
  end
endmodule

// ===== hw/rtl/acr_resolve.sv =====
// ----------------------------------------------------------------------------
// acr_resolve
// Last stage: approach test, hit decision, axis choice and result register.
// ----------------------------------------------------------------------------
`include "aabb_collide_and_resolve_macros.svh"

module acr_resolve
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [2*COORD_BITS+1:0] px,
  input  logic signed [2*COORD_BITS+1:0] py,
  input  logic signed [COORD_BITS+2:0]   ox2,
  input  logic signed [COORD_BITS+2:0]   oy2,
  input  logic signed [COORD_BITS-1:0]   cx,
  input  logic signed [COORD_BITS-1:0]   cy,
  input  logic signed [COORD_BITS-1:0]   mx,
  input  logic signed [COORD_BITS-1:0]   my,
  input  logic signed [COORD_BITS-1:0]   mvx,
  input  logic signed [COORD_BITS-1:0]   mvy,
  acr_out_if.source                      result
);
  localparam int PB = 2 * COORD_BITS + 2;
  localparam int OB = COORD_BITS + 3;

  logic signed [PB:0] dot;
  logic               hit_next;
  logic               push_y;

  assign up_ready = !result.valid || result.ready;

  always_comb begin
    dot      = $signed({px[PB-1], px}) + $signed({py[PB-1], py});
    hit_next = !ox2[OB-1] && (ox2 != '0) && !oy2[OB-1] && (oy2 != '0) && dot[PB];
    // tie on overlap goes to x
    push_y   = hit_next && (ox2 > oy2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result.hit       <= hit_next;
      result.push_axis <= push_y ? AXIS_Y : AXIS_X;
      result.new_x     <= (hit_next && !push_y) ? cx : mx;
      result.new_y     <= push_y ? cy : my;
      result.new_vx    <= (hit_next && !push_y) ? '0 : mvx;
      result.new_vy    <= push_y ? '0 : mvy;
    end
  end

  `ACR_ASSERT_NEXT(a_load_shows, up_valid && up_ready, result.valid, "loaded item not presented")
  `ACR_ASSERT_NOW(a_axis_needs_hit, result.valid && result.push_axis == AXIS_Y, result.hit && result.new_vy == '0, "y push without hit or with y velocity")
  `ACR_ASSERT_NOW(a_x_push_zero, result.valid && result.hit && result.push_axis == AXIS_X, result.new_vx == '0, "x push kept x velocity")
endmodule

// ===== hw/rtl/aabb_collide_and_resolve.sv =====
// ----------------------------------------------------------------------------
// aabb_collide_and_resolve
// Collision test and push-out for a stream of centred box pairs.
// ----------------------------------------------------------------------------
// One box pair is taken every clock while no stage is stalled; its result is
// registered in turn by the difference, multiply and resolve stages. The
// throughput is one item per cycle, set by the three register stages
// (difference, multiply, resolve), each of which holds its item
// independently so bubbles close up under back-pressure. The multiply
// stage, two signed (COORD_BITS+1)-bit products, sets the clock path.
// Coordinates are COORD_BITS wide, sizes COORD_BITS-2 wide, fixed point
// with any number of fraction bits.
module aabb_collide_and_resolve
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  acr_in_if.sink      pair,
  acr_out_if.source   result
);
  localparam int CB = COORD_BITS;

  logic                       v1, v2, r2, r3;
  logic signed [CB:0]         dx, dy, rvx, rvy;
  logic        [CB-SIZE_GAP:0] sumw, sumh;
  logic signed [CB-1:0]       mx1, my1, mvx1, mvy1, tx1, ty1;
  logic signed [2*CB+1:0]     px, py;
  logic signed [CB+2:0]       ox2, oy2;
  logic signed [CB-1:0]       cx, cy, mx2, my2, mvx2, mvy2;

  acr_diff #(.COORD_BITS(CB)) u_diff (
    .clk(clk), .rst(rst), .pair(pair),
    .valid(v1), .dn_ready(r2),
    .dx(dx), .dy(dy), .rvx(rvx), .rvy(rvy), .sumw(sumw), .sumh(sumh),
    .mx(mx1), .my(my1), .mvx(mvx1), .mvy(mvy1), .tx(tx1), .ty(ty1)
  );

  acr_mul #(.COORD_BITS(CB)) u_mul (
    .clk(clk), .rst(rst),
    .up_valid(v1), .up_ready(r2),
    .dx(dx), .dy(dy), .rvx(rvx), .rvy(rvy), .sumw(sumw), .sumh(sumh),
    .mx_in(mx1), .my_in(my1), .mvx_in(mvx1), .mvy_in(mvy1), .tx(tx1), .ty(ty1),
    .valid(v2), .dn_ready(r3),
    .px(px), .py(py), .ox2(ox2), .oy2(oy2), .cx(cx), .cy(cy),
    .mx(mx2), .my(my2), .mvx(mvx2), .mvy(mvy2)
  );

  acr_resolve #(.COORD_BITS(CB)) u_resolve (
    .clk(clk), .rst(rst),
    .up_valid(v2), .up_ready(r3),
    .px(px), .py(py), .ox2(ox2), .oy2(oy2), .cx(cx), .cy(cy),
    .mx(mx2), .my(my2), .mvx(mvx2), .mvy(mvy2),
    .result(result)
  );
endmodule

// ===== verif/aabb_push_checker.sv =====
// ----------------------------------------------------------------------------
// aabb_push_checker
// Watches both channels of the box collision pipeline. Each accepted pair is
// run through a local push-out predictor and its expected result is queued.
// Each accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module aabb_push_checker
  import acr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  acr_in_if    pair,
  acr_out_if   result,
  output int   mismatches,
  output int   outstanding
);

  localparam int SB = COORD_BITS - SIZE_GAP;
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct {
    logic                         hit;
    logic                         axis;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
  } push_result_t;

  push_result_t expected_push_q[$];
  push_result_t want;

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
    return COORD_BITS'(v);
  endfunction

  function automatic push_result_t predict_push_out(
    logic signed [COORD_BITS-1:0] mx, my, mvx, mvy,
    logic        [SB-1:0]         mw, mh,
    logic signed [COORD_BITS-1:0] tx, ty, tvx, tvy,
    logic        [SB-1:0]         tw, th
  );
    longint dx, dy, sumw, sumh, ox2, oy2, dot;
    push_result_t r;
    dx   = longint'(mx) - longint'(tx);
    dy   = longint'(my) - longint'(ty);
    sumw = longint'(mw) + longint'(tw);
    sumh = longint'(mh) + longint'(th);
    // overlaps at double scale, so the half is never lost here
    ox2  = sumw - 2 * (dx < 0 ? -dx : dx);
    oy2  = sumh - 2 * (dy < 0 ? -dy : dy);
    dot  = dx * (longint'(mvx) - longint'(tvx)) + dy * (longint'(mvy) - longint'(tvy));
    r.hit  = 1'b0;
    r.axis = AXIS_X;
    r.x    = mx;
    r.y    = my;
    r.vx   = mvx;
    r.vy   = mvy;
    if (ox2 > 0 && oy2 > 0 && dot < 0) begin
      r.hit = 1'b1;
      // a zero offset lands on the negative side
      if (ox2 > oy2) begin
        r.axis = AXIS_Y;
        r.y    = clamp_coord(dy > 0 ? longint'(ty) + (sumh >> 1) : longint'(ty) - (sumh >> 1));
        r.vy   = '0;
      end else begin
        r.x  = clamp_coord(dx > 0 ? longint'(tx) + (sumw >> 1) : longint'(tx) - (sumw >> 1));
        r.vx = '0;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic signed [COORD_BITS-1:0] exp_v,
                             logic signed [COORD_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_push_q.size() == 0) begin
          $display("%0t: result with no pair outstanding, expected none, got hit %0b x %0d y %0d",
                   $time, result.hit, result.new_x, result.new_y);
          mismatches++;
        end else begin
          want = expected_push_q.pop_front();
          check_field("hit", COORD_BITS'(want.hit), COORD_BITS'(result.hit));
          check_field("push_axis", COORD_BITS'(want.axis), COORD_BITS'(result.push_axis));
          check_field("new_x", want.x, result.new_x);
          check_field("new_y", want.y, result.new_y);
          check_field("new_vx", want.vx, result.new_vx);
          check_field("new_vy", want.vy, result.new_vy);
        end
      end
      if (pair.valid && pair.ready)
        expected_push_q = {expected_push_q, predict_push_out(
          pair.mover_x, pair.mover_y, pair.mover_vx, pair.mover_vy,
          pair.mover_width, pair.mover_height,
          pair.tile_x, pair.tile_y, pair.tile_vx, pair.tile_vy,
          pair.tile_width, pair.tile_height)};
    end
    outstanding = expected_push_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives box pairs into the collision pipeline: a directed set of edge cases
// (touching, ties, zero offsets, saturation, cancelling dot products), then
// random pairs, mostly placed close enough to collide. Both sides stall at
// random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import acr_pkg::*;

  localparam int CB           = 16;
  localparam int SB           = CB - SIZE_GAP;
  localparam int RANDOM_PAIRS = 1900;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk    = 1'b0;
  logic rst    = 1'b1;
  logic steady = 1'b0;
  int   mismatches;
  int   outstanding;
  int   stall_cycles = 0;

  acr_in_if  #(.COORD_BITS(CB)) pair_ch ();
  acr_out_if #(.COORD_BITS(CB)) result_ch ();

  aabb_collide_and_resolve #(.COORD_BITS(CB)) dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch)
  );

  aabb_push_checker #(.COORD_BITS(CB)) push_check (
    .clk         (clk),
    .rst         (rst),
    .pair        (pair_ch),
    .result      (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= rst || steady || ($urandom_range(99) >= 35);
  end

  // end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_pair(int mx, my, mvx, mvy, mw, mh, tx, ty, tvx, tvy, tw, th);
    while (!steady && $urandom_range(99) < 35) begin
      pair_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pair_ch.mover_x      <= CB'(mx);
    pair_ch.mover_y      <= CB'(my);
    pair_ch.mover_vx     <= CB'(mvx);
    pair_ch.mover_vy     <= CB'(mvy);
    pair_ch.mover_width  <= SB'(mw);
    pair_ch.mover_height <= SB'(mh);
    pair_ch.tile_x       <= CB'(tx);
    pair_ch.tile_y       <= CB'(ty);
    pair_ch.tile_vx      <= CB'(tvx);
    pair_ch.tile_vy      <= CB'(tvy);
    pair_ch.tile_width   <= SB'(tw);
    pair_ch.tile_height  <= SB'(th);
    pair_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    pair_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic int rand_vel();
    case ($urandom_range(3))
      0:       return 0;
      3:       return int'($urandom_range(65535)) - 32768;
      default: return int'($urandom_range(128)) - 64;
    endcase
  endfunction

  task automatic send_random_pair();
    int kind, tx, ty, mw, mh, tw, th, sw, sh;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_pair($urandom, $urandom, $urandom, $urandom,
                $urandom_range(16383), $urandom_range(16383),
                $urandom, $urandom, $urandom, $urandom,
                $urandom_range(16383), $urandom_range(16383));
    end else begin
      if (kind < 37) begin
        // near the coordinate limits with big boxes, to push past the range
        tx = $urandom_range(1) ? 32767 - int'($urandom_range(300))
                               : -32768 + int'($urandom_range(300));
        ty = $urandom_range(1) ? 32767 - int'($urandom_range(300))
                               : -32768 + int'($urandom_range(300));
        mw = $urandom_range(16000, 16383);
        mh = $urandom_range(16000, 16383);
        tw = $urandom_range(16000, 16383);
        th = $urandom_range(16000, 16383);
      end else begin
        tx = int'($urandom_range(65535)) - 32768;
        ty = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(9) == 0) begin
          mw = $urandom_range(16383);
          mh = $urandom_range(16383);
          tw = $urandom_range(16383);
          th = $urandom_range(16383);
        end else begin
          mw = $urandom_range(255);
          mh = $urandom_range(255);
          tw = $urandom_range(255);
          th = $urandom_range(255);
        end
      end
      sw = mw + tw + 2;
      sh = mh + th + 2;
      send_pair(tx + int'($urandom_range(sw)) - sw / 2, ty + int'($urandom_range(sh)) - sh / 2,
                rand_vel(), rand_vel(), mw, mh, tx, ty,
                $urandom_range(3) == 0 ? rand_vel() : 0,
                $urandom_range(3) == 0 ? rand_vel() : 0, tw, th);
    end
  endtask

  initial begin
    pair_ch.valid        = 1'b0;
    pair_ch.mover_x      = '0;
    pair_ch.mover_y      = '0;
    pair_ch.mover_vx     = '0;
    pair_ch.mover_vy     = '0;
    pair_ch.mover_width  = '0;
    pair_ch.mover_height = '0;
    pair_ch.tile_x       = '0;
    pair_ch.tile_y       = '0;
    pair_ch.tile_vx      = '0;
    pair_ch.tile_vy      = '0;
    pair_ch.tile_width   = '0;
    pair_ch.tile_height  = '0;
    result_ch.ready      = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // all zero, then the far corners with the largest boxes
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(32767, 32767, 32767, 32767, 16383, 16383,
              -32768, -32768, -32768, -32768, 16383, 16383);
    send_pair(-32768, 0, 32767, 0, 16383, 64, 32767, 0, 0, 0, 16383, 64);
    // push along x, positive and negative side
    send_pair(100, 0, -16, 0, 64, 64, 80, 0, 0, 0, 64, 64);
    send_pair(-20, 5, 16, 0, 64, 64, 0, 0, 0, 0, 64, 64);
    // push along y, positive and negative side
    send_pair(0, 100, 0, -8, 64, 64, 0, 80, 0, 0, 64, 64);
    send_pair(3, -30, 0, 40, 64, 64, 0, 0, 0, 0, 64, 64);
    send_pair(0, -1, 0, 1, 2, 2, 0, 0, 0, 0, 2, 2);
    // equal overlaps pick x
    send_pair(10, 10, -1, -1, 64, 64, 0, 0, 0, 0, 64, 64);
    // zero offset on the push axis goes negative
    send_pair(0, 10, 0, -4, 16, 100, 0, 0, 0, 0, 16, 100);
    // dot product exactly zero, then separating, then mixed signs approaching
    send_pair(4, 3, -3, 4, 64, 64, 0, 0, 0, 0, 64, 64);
    send_pair(4, 3, 5, 5, 64, 64, 0, 0, 0, 0, 64, 64);
    send_pair(4, 3, -5, 4, 64, 64, 0, 0, 0, 0, 64, 64);
    // approach made by the tile's velocity alone
    send_pair(10, 0, 0, 0, 64, 64, 0, 0, 32, 0, 64, 64);
    // edges touching, then just inside
    send_pair(64, 0, -16, 0, 64, 64, 0, 0, 0, 0, 64, 64);
    send_pair(63, 0, -16, 0, 64, 64, 0, 0, 0, 0, 64, 64);
    // placement past the coordinate range saturates
    send_pair(32710, 0, -1, 0, 16383, 16383, 32700, 0, 0, 0, 16383, 16383);
    send_pair(-32710, 0, 1, 0, 16383, 16383, -32700, 0, 0, 0, 16383, 16383);
    send_pair(0, 32710, 0, -1, 16383, 16383, 0, 32700, 0, 0, 16383, 16383);
    send_pair(0, -32710, 0, 1, 16383, 16383, 0, -32700, 0, 0, 16383, 16383);
    // odd size sum truncates the half
    send_pair(5, 0, -1, 0, 33, 100, 0, 0, 0, 0, 30, 100);
    // extreme relative velocities: cancelling, then just negative
    send_pair(1, 1, -32768, 32767, 64, 64, 0, 0, 32767, -32768, 64, 64);
    send_pair(2, 1, -32768, 32767, 64, 64, 0, 0, 32767, -32768, 64, 64);
    // zero-size boxes on one centre
    send_pair(0, 0, -5, -5, 0, 0, 0, 0, 0, 0, 0, 0);
    drain_results();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      steady <= (i >= 900 && i < 1200);
      if (i == 500) drain_results();
      else send_random_pair();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
